FILE: hdl/multi_pattern_url_matcher_macros.svh
// Assertion macros for the URL matcher checker.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef MULTI_PATTERN_URL_MATCHER_MACROS_SVH
`define MULTI_PATTERN_URL_MATCHER_MACROS_SVH

// Same-cycle implication, ignored during reset.
`define MPUM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored during reset.
`define MPUM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset.
`define MPUM_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mpum_pkg.sv
// Package for the URL matcher: pattern byte table and position helpers.
// No dependencies.
package mpum_pkg;

  typedef logic [7:0] char_t;

  localparam int PAT_COUNT = 13;

  localparam int PAT_LEN [PAT_COUNT] = '{
    15, 21, 20, 5, 10, 17, 15, 6, 8, 11, 21, 11, 12
  };

  function automatic int pat_total();
    int acc;
    acc = 0;
    for (int i = 0; i < PAT_COUNT; i++) begin
      acc = acc + PAT_LEN[i];
    end
    return acc;
  endfunction

  localparam int PAT_BYTES = pat_total();

  // All patterns back to back, lower case.
  localparam char_t PAT_CHAR [PAT_BYTES] = '{
    8'h64, 8'h6f, 8'h75, 8'h62, 8'h6c, 8'h65, 8'h63, 8'h6c, 8'h69, 8'h63,
    8'h6b, 8'h2e, 8'h6e, 8'h65, 8'h74,
    8'h67, 8'h6f, 8'h6f, 8'h67, 8'h6c, 8'h65, 8'h73, 8'h79, 8'h6e, 8'h64,
    8'h69, 8'h63, 8'h61, 8'h74, 8'h69, 8'h6f, 8'h6e, 8'h2e, 8'h63, 8'h6f,
    8'h6d,
    8'h67, 8'h6f, 8'h6f, 8'h67, 8'h6c, 8'h65, 8'h2d, 8'h61, 8'h6e, 8'h61,
    8'h6c, 8'h79, 8'h74, 8'h69, 8'h63, 8'h73, 8'h2e, 8'h63, 8'h6f, 8'h6d,
    8'h2f, 8'h61, 8'h64, 8'h73, 8'h2f,
    8'h2f, 8'h61, 8'h64, 8'h73, 8'h65, 8'h72, 8'h76, 8'h65, 8'h72, 8'h2f,
    8'h61, 8'h64, 8'h73, 8'h65, 8'h72, 8'h76, 8'h69, 8'h63, 8'h65, 8'h2e,
    8'h67, 8'h6f, 8'h6f, 8'h67, 8'h6c, 8'h65, 8'h2e,
    8'h66, 8'h61, 8'h63, 8'h65, 8'h62, 8'h6f, 8'h6f, 8'h6b, 8'h2e, 8'h63,
    8'h6f, 8'h6d, 8'h2f, 8'h74, 8'h72,
    8'h70, 8'h69, 8'h78, 8'h65, 8'h6c, 8'h2e,
    8'h74, 8'h72, 8'h61, 8'h63, 8'h6b, 8'h69, 8'h6e, 8'h67,
    8'h75, 8'h74, 8'h6d, 8'h5f, 8'h73, 8'h6f, 8'h75, 8'h72, 8'h63, 8'h65,
    8'h3d,
    8'h73, 8'h63, 8'h6f, 8'h72, 8'h65, 8'h63, 8'h61, 8'h72, 8'h64, 8'h72,
    8'h65, 8'h73, 8'h65, 8'h61, 8'h72, 8'h63, 8'h68, 8'h2e, 8'h63, 8'h6f,
    8'h6d,
    8'h74, 8'h61, 8'h62, 8'h6f, 8'h6f, 8'h6c, 8'h61, 8'h2e, 8'h63, 8'h6f,
    8'h6d,
    8'h6f, 8'h75, 8'h74, 8'h62, 8'h72, 8'h61, 8'h69, 8'h6e, 8'h2e, 8'h63,
    8'h6f, 8'h6d
  };

  localparam char_t UPPER_A     = 8'h41;
  localparam char_t UPPER_Z     = 8'h5a;
  localparam char_t CASE_OFFSET = 8'h20;

  // Position k is the first byte of some pattern.
  function automatic logic pat_head(input int k);
    int   acc;
    logic res;
    acc = 0;
    res = 1'b0;
    for (int i = 0; i < PAT_COUNT; i++) begin
      if (k == acc) res = 1'b1;
      acc = acc + PAT_LEN[i];
    end
    return res;
  endfunction

  // Position k is the final byte of some pattern.
  function automatic logic pat_tail(input int k);
    int   acc;
    logic res;
    acc = 0;
    res = 1'b0;
    for (int i = 0; i < PAT_COUNT; i++) begin
      acc = acc + PAT_LEN[i];
      if (k == acc - 1) res = 1'b1;
    end
    return res;
  endfunction

endpackage

FILE: hdl/multi_pattern_url_matcher.sv
// The result is registered after the final byte leaves the s1 input register; a previous
// result stalled at the output holds that byte in s1 and stalls the input.
// Otherwise one byte per cycle; all pattern prefixes advance together on each byte.
// Reset (rst_n low, synchronous) clears all prefix state, the match latch and both valids.
// Depends on mpum_pkg.
module multi_pattern_url_matcher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_blocked
);

  localparam int NPOS = mpum_pkg::PAT_BYTES;

  logic                 s1_valid_r, s1_valid_nxt;
  mpum_pkg::char_t      s1_char_r;
  logic                 s1_last_r;
  logic                 s1_adv;
  logic                 in_acc;
  mpum_pkg::char_t      fold_char;
  logic [NPOS-1:0]      st_r, st_nxt;
  logic [NPOS-1:0]      hit_vec;
  logic                 hit;
  logic                 match_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_blocked_r;

  assign s1_adv       = s1_valid_r & (~s1_last_r | ~out_valid_r | ~out_stall);
  assign in_stall     = s1_valid_r & ~s1_adv;
  assign in_acc       = in_valid & ~in_stall;
  assign s1_valid_nxt = in_acc | in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last_byte;
    end
  end

  always_comb begin
    if (s1_char_r inside {[mpum_pkg::UPPER_A:mpum_pkg::UPPER_Z]}) begin
      fold_char = s1_char_r + mpum_pkg::CASE_OFFSET;
    end else begin
      fold_char = s1_char_r;
    end
  end

  // One bit per pattern byte: set when the pattern prefix ending there just matched.
  for (genvar k = 0; k < NPOS; k++) begin : g_pos
    localparam logic IS_HEAD = mpum_pkg::pat_head(k);
    localparam logic IS_TAIL = mpum_pkg::pat_tail(k);
    logic prev;
    if (IS_HEAD) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = st_r[k-1];
    end
    assign st_nxt[k]  = prev & (fold_char == mpum_pkg::PAT_CHAR[k]);
    assign hit_vec[k] = IS_TAIL & st_nxt[k];
  end

  assign hit = |hit_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      match_r <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        st_r    <= '0;
        match_r <= 1'b0;
      end else begin
        st_r    <= st_nxt;
        match_r <= match_r | hit;
      end
    end
  end

  assign out_valid_nxt = (s1_adv & s1_last_r) | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_blocked_r <= match_r | hit;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_blocked = out_blocked_r;

endmodule

FILE: hdl/mpum_checker.sv
// Port-level checker for the URL matcher, bound to the top level.
// Depends on multi_pattern_url_matcher_macros.svh.
`include "multi_pattern_url_matcher_macros.svh"

module mpum_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_char_code,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_blocked
);

  `MPUM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_blocked), "stalled result changed")
  `MPUM_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_char_code) && $stable(in_last_byte), "stalled input changed")
  `MPUM_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled while output free")
  `MPUM_ASSERT_RESET(a_reset_idle, !rst_n, !out_valid && !in_stall, "not idle after reset")

endmodule

bind multi_pattern_url_matcher mpum_checker u_mpum_checker (.*);

FILE: dv/multi_pattern_url_matcher_tb.sv
// Self-checking testbench for multi_pattern_url_matcher: directed URLs, then random URLs
// built around the pattern table, checked against a trie-walking predictor in this file.
// Depends on mpum_pkg and the matcher RTL.
module multi_pattern_url_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_OPEN_PATHS = 32;
  localparam int TRIE_NODES     = 256;
  localparam int ASCII_LIMIT    = 128;
  localparam int RANDOM_ITEMS   = 1850;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 20;

  // idle percentage per phase: directed, free-running, sender gaps, receiver stalls, both
  localparam int TX_GAP [5] = '{0, 0, 82, 0, 11};
  localparam int RX_GAP [5] = '{0, 0, 0, 82, 11};

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    logic       want;
  } url_byte_t;

  localparam int N_DIR = 20;
  localparam url_byte_t DIRECTED [N_DIR] = '{
    '{8'h00, 1'b1, 1'b1, 1'b0},
    '{8'hff, 1'b1, 1'b1, 1'b0},
    '{"Z",   1'b1, 1'b1, 1'b0},
    '{"P",   1'b0, 1'b0, 1'b0},
    '{"i",   1'b0, 1'b0, 1'b0},
    '{"X",   1'b0, 1'b0, 1'b0},
    '{"E",   1'b0, 1'b0, 1'b0},
    '{"l",   1'b0, 1'b0, 1'b0},
    '{".",   1'b1, 1'b1, 1'b1},
    '{"/",   1'b0, 1'b0, 1'b0},
    '{"A",   1'b0, 1'b0, 1'b0},
    '{"D",   1'b0, 1'b0, 1'b0},
    '{"S",   1'b0, 1'b0, 1'b0},
    '{"/",   1'b1, 1'b1, 1'b1},
    '{"/",   1'b0, 1'b0, 1'b0},
    '{"a",   1'b0, 1'b0, 1'b0},
    '{"d",   1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0},
    '{"s",   1'b0, 1'b0, 1'b0},
    '{"/",   1'b1, 1'b1, 1'b0}
  };

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic       out_blocked;

  multi_pattern_url_matcher DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_blocked  (out_blocked)
  );

  url_byte_t   url_q[$];
  logic        blocked_due[$];
  int          next_idx   = 0;
  int          in_acc_cnt = 0;
  int          err_cnt    = 0;
  int          hold_left  = 0;
  bit          hold_done  = 1'b0;
  int          pat_base [mpum_pkg::PAT_COUNT];

  int unsigned trie_next [TRIE_NODES][ASCII_LIMIT];
  bit          trie_term [TRIE_NODES];
  int unsigned path_at   [MAX_OPEN_PATHS];
  bit          path_open [MAX_OPEN_PATHS];
  bit          match_latch;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] fold_case(logic [7:0] ch);
    return (ch >= mpum_pkg::UPPER_A && ch <= mpum_pkg::UPPER_Z) ?
           ch + mpum_pkg::CASE_OFFSET : ch;
  endfunction

  // Walks every open path one byte deeper; returns the verdict on the final byte.
  function automatic void scan_url_byte(input logic [7:0] raw, input logic fin,
                                        output bit emit, output bit verdict);
    logic [7:0]  c;
    int unsigned nxt;
    bit          placed;
    c = fold_case(raw);
    if (c >= ASCII_LIMIT) begin
      for (int k = 0; k < MAX_OPEN_PATHS; k++) path_open[k] = 1'b0;
    end else begin
      for (int k = 0; k < MAX_OPEN_PATHS; k++) begin
        if (path_open[k]) begin
          nxt = trie_next[path_at[k]][c[6:0]];
          if (nxt == 0) begin
            path_open[k] = 1'b0;
            path_at[k]   = 0;
          end else begin
            path_at[k] = nxt;
            if (trie_term[nxt]) match_latch = 1'b1;
          end
        end
      end
      nxt = trie_next[0][c[6:0]];
      if (nxt != 0) begin
        if (trie_term[nxt]) match_latch = 1'b1;
        placed = 1'b0;
        for (int k = 0; k < MAX_OPEN_PATHS; k++) begin
          if (!placed && !path_open[k]) begin
            path_open[k] = 1'b1;
            path_at[k]   = nxt;
            placed       = 1'b1;
          end
        end
      end
    end
    emit    = fin;
    verdict = match_latch;
    if (fin) begin
      for (int k = 0; k < MAX_OPEN_PATHS; k++) begin
        path_open[k] = 1'b0;
        path_at[k]   = 0;
      end
      match_latch = 1'b0;
    end
  endfunction

  function automatic int phase_of(int idx);
    int ph;
    if (idx < N_DIR) return 0;
    ph = 1 + (idx - N_DIR) * 4 / (url_q.size() - N_DIR + 1);
    return (ph > 4) ? 4 : ph;
  endfunction

  function automatic logic [7:0] mixed_case(logic [7:0] ch);
    if (ch >= mpum_pkg::UPPER_A + mpum_pkg::CASE_OFFSET &&
        ch <= mpum_pkg::UPPER_Z + mpum_pkg::CASE_OFFSET && $urandom_range(1))
      return ch - mpum_pkg::CASE_OFFSET;
    return ch;
  endfunction

  function automatic void add_byte(logic [7:0] ch);
    url_byte_t b;
    b       = '0;
    b.ch    = ch;
    url_q.push_back(b);
  endfunction

  function automatic void add_text(int p, int from, int upto);
    for (int j = from; j < upto; j++)
      add_byte(mixed_case(mpum_pkg::PAT_CHAR[pat_base[p] + j]));
  endfunction

  // bytes drawn mostly from the pattern alphabet, now and then any byte at all
  function automatic void add_noise(int n);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(15) == 0) add_byte(8'($urandom_range(255)));
      else add_byte(mixed_case(mpum_pkg::PAT_CHAR[$urandom_range(mpum_pkg::PAT_BYTES - 1)]));
    end
  endfunction

  function automatic void end_url();
    url_byte_t b;
    b     = url_q.pop_back();
    b.fin = 1'b1;
    url_q.push_back(b);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (next_idx < url_q.size() && $urandom_range(99) >= TX_GAP[phase_of(next_idx)]) begin
        in_valid     <= 1'b1;
        in_char_code <= url_q[next_idx].ch;
        in_last_byte <= url_q[next_idx].fin;
        next_idx     <= next_idx + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_acc_cnt >= N_DIR + 20) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < RX_GAP[phase_of(next_idx)]);
    end
  end

  always @(posedge clk) begin : monitor
    url_byte_t b;
    bit        emit;
    bit        verdict;
    logic      want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        b = url_q[in_acc_cnt];
        scan_url_byte(b.ch, b.fin, emit, verdict);
        if (emit) blocked_due.push_back(b.typed ? b.want : verdict);
        in_acc_cnt <= in_acc_cnt + 1;
      end
      if (out_valid && !out_stall) begin
        if (blocked_due.size() == 0) begin
          $error("blocked: no transaction expected, actual %0b", out_blocked);
          err_cnt++;
        end else begin
          want = blocked_due.pop_front();
          if (out_blocked !== want) begin
            $error("blocked: expected %0b, actual %0b", want, out_blocked);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int used, node, p, cut, acc;
    bit ok;
    logic [7:0] c;

    acc = 0;
    for (int i = 0; i < mpum_pkg::PAT_COUNT; i++) begin
      pat_base[i] = acc;
      acc += mpum_pkg::PAT_LEN[i];
    end

    // pattern trie, node 0 is the root
    used = 1;
    for (int i = 0; i < mpum_pkg::PAT_COUNT; i++) begin
      node = 0;
      ok   = 1'b1;
      for (int j = 0; j < mpum_pkg::PAT_LEN[i] && ok; j++) begin
        c = fold_case(mpum_pkg::PAT_CHAR[pat_base[i] + j]);
        if (c < ASCII_LIMIT) begin
          if (trie_next[node][c[6:0]] == 0) begin
            if (used >= TRIE_NODES) ok = 1'b0;
            else begin
              trie_next[node][c[6:0]] = used;
              used++;
            end
          end
          if (ok) node = trie_next[node][c[6:0]];
        end
      end
      if (ok) trie_term[node] = 1'b1;
    end
    match_latch = 1'b0;

    for (int i = 0; i < N_DIR; i++) url_q.push_back(DIRECTED[i]);

    while (url_q.size() < N_DIR + RANDOM_ITEMS) begin
      p   = $urandom_range(mpum_pkg::PAT_COUNT - 1);
      cut = $urandom_range(mpum_pkg::PAT_LEN[p] - 1, 1);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          add_noise($urandom_range(8));
          add_text(p, 0, mpum_pkg::PAT_LEN[p]);
          add_noise($urandom_range(8));
        end
        4: begin
          add_noise($urandom_range(4));
          add_text(p, 0, cut);
          add_byte($urandom_range(1) ? 8'(8'h80 | $urandom_range(127)) : 8'($urandom_range(255)));
          add_text(p, cut, mpum_pkg::PAT_LEN[p]);
        end
        5: begin
          add_text(p, 0, cut);
          add_text(p, 0, mpum_pkg::PAT_LEN[p]);
          add_noise($urandom_range(3));
        end
        6: begin
          for (int j = $urandom_range(24, 1); j > 0; j--) add_byte(8'($urandom_range(255)));
        end
        default: add_noise($urandom_range(40, 1));
      endcase
      end_url();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (in_acc_cnt == url_q.size());
    wait (blocked_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
